FILE: rtl/dual_wheel_pid_position_drive_assert.svh
// Assertion macros for the dual-wheel position drive checker.
// Included by the checker module; no other dependencies.
`ifndef DUAL_WHEEL_PID_POSITION_DRIVE_ASSERT_SVH
`define DUAL_WHEEL_PID_POSITION_DRIVE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/dwpd_pkg.sv
// Shared types and constants for the dual-wheel position drive.
// No dependencies.
`default_nettype none
package dwpd_pkg;
  localparam int COUNT_BITS_DEF     = 32;
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int SUM_BITS_DEF       = 48;
  localparam int DUTY_MAX_DEF       = 255;

  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 32;
  localparam int DT_W    = 20;
  localparam int ACC_W   = 72;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_DERIV = 2'd1;
  localparam logic [1:0] REG_INTEG = 2'd2;

  localparam logic [23:0] PROP_RST  = 24'd409600;
  localparam logic [23:0] DERIV_RST = 24'd614;
  localparam logic [23:0] INTEG_RST = 24'd0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_DMUL, ST_DDIV, ST_EMUL, ST_SUM, ST_PMUL, ST_DGMUL,
    ST_IMUL, ST_IDIV, ST_ADD, ST_OUT, ST_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/dwpd_wheel.sv
// One-wheel PID engine: shared bit-serial multiplier and restoring divider.
// Depends on dwpd_pkg.
`default_nettype none
module dwpd_wheel #(
  parameter int COUNT_BITS     = dwpd_pkg::COUNT_BITS_DEF,
  parameter int GAIN_FRAC_BITS = dwpd_pkg::GAIN_FRAC_BITS_DEF,
  parameter int SUM_BITS       = dwpd_pkg::SUM_BITS_DEF,
  parameter int DUTY_MAX       = dwpd_pkg::DUTY_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       invert,
  input  wire logic [COUNT_BITS-1:0]      position,
  input  wire logic [31:0]                target,
  input  wire logic [dwpd_pkg::DT_W-1:0]  dt,
  input  wire logic [dwpd_pkg::GAIN_W-1:0] kp,
  input  wire logic [dwpd_pkg::GAIN_W-1:0] kd,
  input  wire logic [dwpd_pkg::GAIN_W-1:0] ki,
  output logic                            done,
  output logic                            dir_pin,
  output logic [7:0]                      duty
);
  import dwpd_pkg::*;

  localparam int CW = 6;
  localparam logic [CW-1:0] MUL_LAST = CW'(GAIN_W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(63);
  localparam logic [63:0] CAP = 64'd1 << 60;
  localparam logic signed [63:0] SUM_HI = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic signed [ERR_W-1:0] err, last_err;
  logic signed [SUM_BITS-1:0] esum;
  logic signed [63:0] acc;          // running control sum
  logic [63:0] mag;                 // multiplicand, or dividend shifting into quotient
  logic [63:0] prod;                // partial product, or remainder
  logic [GAIN_W-1:0] mulr;          // multiplier, MSB first
  logic [DT_W-1:0] dvsr;
  logic [63:0] dmag;                // derivative magnitude
  logic [63:0] incmag;              // |e * dt|
  logic dneg;                       // sign of the error change

  logic signed [ERR_W-1:0] e_now;
  logic signed [ERR_W:0] de_now;
  logic [64:0] p2, r, rsub;
  logic [63:0] pstep, term, qbits;
  logic ge, mul_last, div_last;
  logic signed [63:0] esum_w, inc, sum_sat;
  logic [63:0] umag, pw;
  logic [7:0] p8;

  function automatic logic [63:0] absv(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  assign mul_last = (cnt == MUL_LAST);
  assign div_last = (cnt == DIV_LAST);

  // error and its change against the last step
  assign e_now  = ERR_W'(32'(signed'(position)) - target);
  assign de_now = (ERR_W+1)'(e_now) - (ERR_W+1)'(last_err);

  // one multiply step; a product past the cap sticks above it
  assign p2    = {prod, 1'b0} + (mulr[GAIN_W-1] ? {1'b0, mag} : 65'd0);
  assign pstep = (p2 > {1'b0, CAP}) ? CAP + 64'd1 : p2[63:0];
  assign term  = (p2 > {1'b0, CAP}) ? CAP : p2[63:0];

  // one restoring divide step
  assign r     = {prod, mag[63]};
  assign ge    = (r >= {45'd0, dvsr});
  assign rsub  = r - {45'd0, dvsr};
  assign qbits = {mag[62:0], ge};

  // saturating error sum
  always_comb begin
    esum_w = 64'(esum);
    inc = err[ERR_W-1] ? -$signed(incmag) : $signed(incmag);
    if (inc > 64'sd0 && esum_w > SUM_HI - inc) sum_sat = SUM_HI;
    else if (inc < 64'sd0 && esum_w < SUM_LO - inc) sum_sat = SUM_LO;
    else sum_sat = esum_w + inc;
  end

  // drive level from the control sum
  assign umag = absv(acc);
  assign pw   = umag >> GAIN_FRAC_BITS;
  assign p8   = (pw > 64'(DUTY_MAX)) ? 8'(DUTY_MAX) : pw[7:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    done = (state == ST_DONE);
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ERR;
      ST_ERR:   state_next = ST_DMUL;
      ST_DMUL:  if (mul_last) state_next = (dt == '0) ? ST_EMUL : ST_DDIV;
      ST_DDIV:  if (div_last) state_next = ST_EMUL;
      ST_EMUL:  if (mul_last) state_next = ST_SUM;
      ST_SUM:   state_next = ST_PMUL;
      ST_PMUL:  if (mul_last) state_next = ST_DGMUL;
      ST_DGMUL: if (mul_last) state_next = ST_IMUL;
      ST_IMUL:  if (mul_last) state_next = ST_IDIV;
      ST_IDIV:  if (div_last) state_next = ST_ADD;
      ST_ADD:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      last_err <= '0;
      esum <= '0;
      dir_pin <= 1'b0;
      duty <= '0;
    end else begin
      cnt <= (state_next != state) ? '0 : cnt + CW'(1);
      unique case (state)
        ST_ERR: begin
          // |de| * 1e6 next
          err  <= e_now;
          dneg <= de_now[ERR_W];
          mag  <= absv(64'(de_now));
          mulr <= GAIN_W'(USEC_PER_SEC);
          prod <= '0;
        end
        ST_DMUL: begin
          if (mul_last && dt != '0) begin
            mag <= term; prod <= '0; dvsr <= dt;
          end else if (mul_last) begin
            dmag <= '0; mag <= absv(64'(err)); mulr <= GAIN_W'(dt); prod <= '0;
          end else begin
            prod <= pstep; mulr <= mulr << 1;
          end
        end
        ST_DDIV: begin
          if (div_last) begin
            dmag <= qbits; mag <= absv(64'(err)); mulr <= GAIN_W'(dt); prod <= '0;
          end else begin
            prod <= ge ? rsub[63:0] : r[63:0]; mag <= qbits;
          end
        end
        ST_EMUL: begin
          if (mul_last) incmag <= term;
          else begin
            prod <= pstep; mulr <= mulr << 1;
          end
        end
        ST_SUM: begin
          esum <= SUM_BITS'(sum_sat);
          last_err <= err;
          mag <= absv(64'(err)); mulr <= kp; prod <= '0;
        end
        ST_PMUL: begin
          if (mul_last) begin
            acc <= err[ERR_W-1] ? -$signed(term) : $signed(term);
            mag <= dmag; mulr <= kd; prod <= '0;
          end else begin
            prod <= pstep; mulr <= mulr << 1;
          end
        end
        ST_DGMUL: begin
          if (mul_last) begin
            acc <= acc + (dneg ? -$signed(term) : $signed(term));
            mag <= absv(esum_w); mulr <= ki; prod <= '0;
          end else begin
            prod <= pstep; mulr <= mulr << 1;
          end
        end
        ST_IMUL: begin
          if (mul_last) begin
            mag <= term; prod <= '0; dvsr <= USEC_PER_SEC;
          end else begin
            prod <= pstep; mulr <= mulr << 1;
          end
        end
        ST_IDIV: begin
          prod <= ge ? rsub[63:0] : r[63:0]; mag <= qbits;
        end
        ST_ADD: acc <= acc + (esum_w[63] ? -$signed(mag) : $signed(mag));
        ST_OUT: begin
          if (acc[63] != invert) begin
            dir_pin <= 1'b0; duty <= p8;
          end else begin
            dir_pin <= 1'b1; duty <= 8'(DUTY_MAX) - p8;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dual_wheel_pid_position_drive.sv
// Top level of the dual-wheel position drive: encoder counters, gain
// registers, output register and two dwpd_wheel engines. Depends on dwpd_pkg.
`default_nettype none
// An item is taken when in_valid is high and in_stall low; its edges are
// counted at once. Items without update answer on the next cycle. An update
// item starts both wheels' PID engines together; each runs a 24-step serial
// multiply of the error change by 1e6, a 64-step restoring divide by the
// elapsed time (skipped when it is zero), four more 24-step multiplies (error
// times time, then the three gains) and a 64-step divide by 1e6, after which
// the drive levels are set. One item is in work at a time; the result waits
// in an output register.
module dual_wheel_pid_position_drive #(
  parameter int COUNT_BITS     = dwpd_pkg::COUNT_BITS_DEF,
  parameter int GAIN_FRAC_BITS = dwpd_pkg::GAIN_FRAC_BITS_DEF,
  parameter int SUM_BITS       = dwpd_pkg::SUM_BITS_DEF,
  parameter int DUTY_MAX       = dwpd_pkg::DUTY_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        left_edge,
  input  wire logic        left_phase_b,
  input  wire logic        right_edge,
  input  wire logic        right_phase_b,
  input  wire logic        update,
  input  wire logic [19:0] elapsed_us,
  input  wire logic signed [31:0] left_target,
  input  wire logic signed [31:0] right_target,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             left_dir_pin,
  output logic [7:0]       left_duty,
  output logic             right_dir_pin,
  output logic [7:0]       right_duty,
  output logic signed [31:0] left_count,
  output logic signed [31:0] right_count
);
  import dwpd_pkg::*;

  logic [23:0] kp, kd, ki;
  logic [COUNT_BITS-1:0] lpos, rpos;
  logic busy, run, ldone, rdone, lfin, rfin;
  logic [19:0] dt;
  logic [31:0] ltgt, rtgt;
  logic ldir, rdir;
  logic [7:0] ldut, rdut;

  assign in_stall = busy | out_valid;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= PROP_RST; kd <= DERIV_RST; ki <= INTEG_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_PROP) kp <= cfg_data;
      if (cfg_index == REG_DERIV) kd <= cfg_data;
      if (cfg_index == REG_INTEG) ki <= cfg_data;
    end
  end

  // Encoder counts, item control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lpos <= '0; rpos <= '0; busy <= 1'b0; run <= 1'b0;
      out_valid <= 1'b0; lfin <= 1'b0; rfin <= 1'b0;
    end else begin
      run <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_valid && !in_stall) begin
        if (left_edge)
          lpos <= left_phase_b ? lpos + COUNT_BITS'(1) : lpos - COUNT_BITS'(1);
        if (right_edge)
          rpos <= right_phase_b ? rpos - COUNT_BITS'(1) : rpos + COUNT_BITS'(1);
        dt <= elapsed_us; ltgt <= left_target; rtgt <= right_target;
        if (update) begin
          busy <= 1'b1; run <= 1'b1; lfin <= 1'b0; rfin <= 1'b0;
        end else
          out_valid <= 1'b1;
      end
      if (ldone) lfin <= 1'b1;
      if (rdone) rfin <= 1'b1;
      if (busy && (lfin || ldone) && (rfin || rdone)) begin
        busy <= 1'b0; out_valid <= 1'b1;
      end
    end
  end

  dwpd_wheel #(.COUNT_BITS(COUNT_BITS), .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .SUM_BITS(SUM_BITS), .DUTY_MAX(DUTY_MAX)) u_left (
    .clk, .rst, .start(run), .invert(1'b0), .position(lpos), .target(ltgt),
    .dt, .kp, .kd, .ki, .done(ldone), .dir_pin(ldir), .duty(ldut));

  dwpd_wheel #(.COUNT_BITS(COUNT_BITS), .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .SUM_BITS(SUM_BITS), .DUTY_MAX(DUTY_MAX)) u_right (
    .clk, .rst, .start(run), .invert(1'b1), .position(rpos), .target(rtgt),
    .dt, .kp, .kd, .ki, .done(rdone), .dir_pin(rdir), .duty(rdut));

  assign left_dir_pin  = ldir;
  assign left_duty     = ldut;
  assign right_dir_pin = rdir;
  assign right_duty    = rdut;
  assign left_count    = 32'(signed'(lpos));
  assign right_count   = 32'(signed'(rpos));
endmodule
`default_nettype wire

FILE: rtl/dwpd_checker.sv
// Port-level checker for the dual-wheel position drive, bound to the top.
// Depends on dual_wheel_pid_position_drive_assert.svh.
`default_nettype none
`include "dual_wheel_pid_position_drive_assert.svh"
module dwpd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] left_duty
);
  // a waiting result blocks new beats
  `DW_ASSERT_IMP(a_stall_out, clk, rst, out_valid, in_stall)
  // a stalled result stays
  `DW_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(left_duty))
  // an accepted beat stalls input next cycle
  `DW_ASSERT_NEXT(a_one, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind dual_wheel_pid_position_drive dwpd_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .left_duty);
`default_nettype wire
